@@ src/midpoint_circle_rasterizer_core_defines.svh @@
// Assertion macros for the midpoint circle rasterizer.
// No dependencies; included by the top level.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/mcr_pkg.sv @@
// Shared widths, constants and the step record of the circle rasterizer.
// No dependencies.
package mcr_pkg;
    localparam int COORD_BITS = 10;
    localparam int OUT_BITS   = COORD_BITS + 2;
    localparam int OFF_BITS   = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int COL_BITS   = 8;
    localparam int PIX_PER_STEP = 8;
    localparam int IDX_BITS   = $clog2(PIX_PER_STEP);
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0]    cx;
        logic [COORD_BITS-1:0]    cy;
        logic signed [OFF_BITS-1:0] xo;
        logic signed [OFF_BITS-1:0] yo;
        logic [COL_BITS-1:0]      colour;
        logic                     done;
    } t_step;
endpackage

@@ src/mcr_front.sv @@
// Front end: accepts items, holds circle state, emits step records.
// Depends on mcr_pkg.
module mcr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_kind,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_radius,
    input  logic [mcr_pkg::COL_BITS-1:0]   i_colour,
    output logic                        o_push,
    output mcr_pkg::t_step              o_step,
    output logic                        o_active
);
    import mcr_pkg::*;

    logic                       r_active;
    logic [COORD_BITS-1:0]      r_cx;
    logic [COORD_BITS-1:0]      r_cy;
    logic [COL_BITS-1:0]        r_colour;
    logic signed [OFF_BITS-1:0] r_xo, n_xo;
    logic signed [OFF_BITS-1:0] r_yo, n_yo;
    logic signed [DEC_BITS-1:0] r_dec, n_dec;
    logic signed [DEC_BITS-1:0] xo4, yo4, dec_init;
    logic                       n_done;

    always_comb begin
        xo4 = signed'(DEC_BITS'(r_xo)) <<< 2;
        yo4 = signed'(DEC_BITS'(r_yo)) <<< 2;
        dec_init = DEC_BITS'(3) - (signed'(DEC_BITS'(i_radius)) <<< 1);
        if (r_dec <= 0) begin
            n_dec = r_dec + xo4 + DEC_BITS'(6);
            n_yo  = r_yo;
        end else begin
            n_dec = r_dec + xo4 - yo4 + DEC_BITS'(10);
            n_yo  = r_yo - OFF_BITS'(1);
        end
        n_xo   = r_xo + OFF_BITS'(1);
        n_done = n_xo > n_yo;
    end

    assign o_push        = i_accept && (i_kind == KIND_STEP) && r_active;
    assign o_step.cx     = r_cx;
    assign o_step.cy     = r_cy;
    assign o_step.xo     = r_xo;
    assign o_step.yo     = r_yo;
    assign o_step.colour = r_colour;
    assign o_step.done   = n_done;
    assign o_active      = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_accept && i_kind == KIND_START) begin
            r_active <= 1'b1;
        end else if (o_push && n_done) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_kind == KIND_START) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_colour <= i_colour;
            r_xo     <= '0;
            r_yo     <= signed'(OFF_BITS'(i_radius));
            r_dec    <= dec_init;
        end else if (o_push) begin
            r_xo  <= n_xo;
            r_yo  <= n_yo;
            r_dec <= n_dec;
        end
    end
endmodule

@@ src/mcr_queue.sv @@
// Short queue of step records between front and back end.
// Depends on mcr_pkg.
module mcr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcr_pkg::t_step i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mcr_pkg::t_step o_data
);
    import mcr_pkg::*;

    t_step                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = r_cnt == QCNT_BITS'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ src/mcr_back.sv @@
// Back end: expands one step record into eight pixels in an output register.
// Depends on mcr_pkg.
module mcr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  mcr_pkg::t_step               i_q_data,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [mcr_pkg::OUT_BITS-1:0] o_pixel_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0] o_pixel_y,
    output logic [mcr_pkg::COL_BITS-1:0] o_pixel_colour,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);
    import mcr_pkg::*;

    t_step                      r_cur;
    logic                       r_busy;
    logic [IDX_BITS-1:0]        r_idx;
    logic                       r_ovalid;
    logic signed [OUT_BITS-1:0] r_px, r_py;
    logic [COL_BITS-1:0]        r_col;
    logic                       r_last, r_done;
    logic                       out_adv, idx_last;
    logic signed [OFF_BITS-1:0] off_a, off_b;
    logic signed [OUT_BITS-1:0] base_x, base_y, n_px, n_py;

    assign out_adv  = !r_ovalid || i_pop;
    assign idx_last = r_idx == IDX_BITS'(PIX_PER_STEP - 1);
    assign o_q_pop  = i_q_valid && (!r_busy || (out_adv && idx_last));

    always_comb begin
        off_a  = r_idx[IDX_BITS-1] ? r_cur.yo : r_cur.xo;
        off_b  = r_idx[IDX_BITS-1] ? r_cur.xo : r_cur.yo;
        base_x = signed'(OUT_BITS'(r_cur.cx));
        base_y = signed'(OUT_BITS'(r_cur.cy));
        n_px   = r_idx[0] ? base_x - off_a : base_x + off_a;
        n_py   = (r_idx[0] ^ r_idx[1]) ? base_y - off_b : base_y + off_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_ovalid <= r_busy;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_adv && r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (idx_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        if (out_adv && r_busy) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_col  <= r_cur.colour;
            r_last <= idx_last;
            r_done <= idx_last && r_cur.done;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_colour = r_col;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;
endmodule

@@ src/midpoint_circle_rasterizer_core.sv @@
// Midpoint circle rasterizer with eight-way symmetry, top level.
// Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back and the defines header.
//
// Usage: items enter through a queue-style port (push, full). A start item
// (kind 0) loads centre, radius and colour and yields nothing. A step item
// (kind 1) while a circle runs yields eight pixels; a step while idle is
// dropped. Pixels leave through a queue-style port (empty, pop): the
// oldest pixel sits on the ports while empty is low.
// Latency: a step accepted into an idle block passes the step queue entry,
// the expander's step register and then its output register. Throughput:
// one pixel per cycle while pop is high, set by the single output register.
// Start items and queued steps are taken every cycle while full is low;
// the front computes the next offsets in the cycle of acceptance and a
// two-entry step queue buffers records for the expander.
// Reset: no circle is active and both queues are empty.
// Stall: while pop is low the current pixel holds, the expander stops, the
// step queue fills and then full rises.
`include "midpoint_circle_rasterizer_core_defines.svh"
module midpoint_circle_rasterizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_kind,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [mcr_pkg::COORD_BITS-1:0] i_radius,
    input  logic [mcr_pkg::COL_BITS-1:0]   i_colour,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [mcr_pkg::OUT_BITS-1:0] o_pixel_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0] o_pixel_y,
    output logic [mcr_pkg::COL_BITS-1:0] o_pixel_colour,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);
    import mcr_pkg::*;

    logic   q_push, q_full;
    t_step  push_step, q_data;
    logic   accept, active, q_valid, q_pop;

    assign accept = push && !q_full;
    assign full   = q_full;

    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_kind),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_colour   (i_colour),
        .o_push     (q_push),
        .o_step     (push_step),
        .o_active   (active)
    );

    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_step),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    mcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    `MCR_ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, !empty && o_circle_done, o_last_of_step)
    `MCR_ASSERT_NEXT(a_start_sets_active, i_clk, i_rst_n, accept && i_kind == KIND_START, active)
    `MCR_ASSERT_NEXT(a_step_contiguous, i_clk, i_rst_n, !empty && pop && !o_last_of_step, !empty)
    `MCR_ASSERT_IMPL(a_idle_step_no_push, i_clk, i_rst_n, !active, !q_push)
endmodule

@@ dv/tb_midpoint_circle_rasterizer_core.sv @@
// Self-checking testbench for midpoint_circle_rasterizer_core: a directed table, then random
// circle sequences, checked pixel by pixel against a circle-stepping predictor.
// Depends on mcr_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module tb_midpoint_circle_rasterizer_core;
    import mcr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 21;
    localparam int RAND_ITEMS  = 500;

    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_CENTRE} t_chk;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] r;
        logic [COL_BITS-1:0]   col;
        t_chk                  chk;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COL_BITS-1:0]   ecol;
    } t_stim_row;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic [COL_BITS-1:0]        col;
        logic                       last;
        logic                       done;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic                  i_kind = KIND_START;
    logic [COORD_BITS-1:0] i_center_x = '0;
    logic [COORD_BITS-1:0] i_center_y = '0;
    logic [COORD_BITS-1:0] i_radius = '0;
    logic [COL_BITS-1:0]   i_colour = '0;
    logic                  full;
    logic                  empty;
    logic signed [OUT_BITS-1:0] o_pixel_x;
    logic signed [OUT_BITS-1:0] o_pixel_y;
    logic [COL_BITS-1:0]   o_pixel_colour;
    logic                  o_last_of_step;
    logic                  o_circle_done;

    logic                       circle_active = 1'b0;
    logic [COORD_BITS-1:0]      circle_cx = '0;
    logic [COORD_BITS-1:0]      circle_cy = '0;
    logic [COL_BITS-1:0]        circle_col = '0;
    logic signed [OFF_BITS-1:0] circle_xo = '0;
    logic signed [OFF_BITS-1:0] circle_yo = '0;
    logic signed [DEC_BITS-1:0] circle_dec = '0;

    t_pixel      pixels_due_q[$];
    t_pixel      pixel_due;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_span = 0;
    logic        rx_hold = 1'b0;
    bit          random_phase = 1'b0;

    t_stim_row dir_rows [DIR_ROWS] = '{
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_NONE,   10'd0,    10'd0,    8'h00},
        '{KIND_START, 10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd1023, 10'd1023, 10'd1023, 8'hFF, CHK_CENTRE, 10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_NONE,   10'd0,    10'd0,    8'h00},
        '{KIND_START, 10'd1023, 10'd1023, 10'd0,    8'hFF, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_CENTRE, 10'd1023, 10'd1023, 8'hFF},
        '{KIND_START, 10'd0,    10'd0,    10'd1023, 8'hA5, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_START, 10'd1023, 10'd1023, 10'd1023, 8'h5A, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_START, 10'd512,  10'd512,  10'd1,    8'hFF, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_START, 10'd100,  10'd200,  10'd3,    8'h0F, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00},
        '{KIND_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PRED,   10'd0,    10'd0,    8'h00}
    };

    midpoint_circle_rasterizer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_colour       (i_colour),
        .empty          (empty),
        .pop            (pop),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void plot_circle_step(input t_stim_row row, input bit record);
        int     cx;
        int     cy;
        int     xo;
        int     yo;
        int     dec;
        int     px [8];
        int     py [8];
        t_pixel pix;
        if (row.kind == KIND_START) begin
            circle_cx     = row.cx;
            circle_cy     = row.cy;
            circle_col    = row.col;
            circle_dec    = DEC_BITS'(3 - 2 * int'(row.r));
            circle_xo     = '0;
            circle_yo     = OFF_BITS'(int'(row.r));
            circle_active = 1'b1;
            return;
        end
        if (!circle_active) return;
        cx  = int'(circle_cx);
        cy  = int'(circle_cy);
        xo  = int'(circle_xo);
        yo  = int'(circle_yo);
        dec = int'(circle_dec);
        px = '{cx + xo, cx - xo, cx + xo, cx - xo, cx + yo, cx - yo, cx + yo, cx - yo};
        py = '{cy + yo, cy - yo, cy - yo, cy + yo, cy + xo, cy - xo, cy - xo, cy + xo};
        if (dec <= 0) begin
            dec = dec + 4 * xo + 6;
        end else begin
            dec = dec + 4 * xo - 4 * yo + 10;
            yo  = yo - 1;
        end
        xo = xo + 1;
        circle_dec = DEC_BITS'(dec);
        circle_xo  = OFF_BITS'(xo);
        circle_yo  = OFF_BITS'(yo);
        if (xo > yo) circle_active = 1'b0;
        if (record) begin
            for (int k = 0; k < PIX_PER_STEP; k++) begin
                pix.x    = OUT_BITS'(px[k]);
                pix.y    = OUT_BITS'(py[k]);
                pix.col  = circle_col;
                pix.last = (k == PIX_PER_STEP - 1);
                pix.done = (k == PIX_PER_STEP - 1) && (xo > yo);
                pixels_due_q.push_back(pix);
            end
        end
    endfunction

    function automatic t_stim_row rand_row(input logic kind);
        t_stim_row row;
        row.kind = kind;
        row.cx   = COORD_BITS'($urandom);
        row.cy   = COORD_BITS'($urandom);
        row.r    = COORD_BITS'($urandom);
        row.col  = COL_BITS'($urandom);
        row.chk  = CHK_PRED;
        row.ex   = '0;
        row.ey   = '0;
        row.ecol = '0;
        return row;
    endfunction

    task automatic offer(input t_stim_row row);
        t_pixel pix;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push       <= 1'b1;
        i_kind     <= row.kind;
        i_center_x <= row.cx;
        i_center_y <= row.cy;
        i_radius   <= row.r;
        i_colour   <= row.col;
        do @(posedge i_clk); while (full);
        if (row.kind == KIND_START || circle_active) items_sent++;
        plot_circle_step(row, row.chk == CHK_PRED);
        if (row.chk == CHK_CENTRE) begin
            for (int k = 0; k < PIX_PER_STEP; k++) begin
                pix.x    = OUT_BITS'(row.ex);
                pix.y    = OUT_BITS'(row.ey);
                pix.col  = row.ecol;
                pix.last = (k == PIX_PER_STEP - 1);
                pix.done = (k == PIX_PER_STEP - 1);
                pixels_due_q.push_back(pix);
            end
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pixels_due_q.size() != 0);
    endtask

    // receiver: compare each transfer, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pixels_due_q.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d", $time,
                         o_pixel_x, o_pixel_y, o_pixel_colour);
                mismatches++;
            end else begin
                pixel_due = pixels_due_q.pop_front();
                if (o_pixel_x !== pixel_due.x) begin
                    $display("%0t: pixel_x expected %0d actual %0d", $time,
                             pixel_due.x, o_pixel_x);
                    mismatches++;
                end
                if (o_pixel_y !== pixel_due.y) begin
                    $display("%0t: pixel_y expected %0d actual %0d", $time,
                             pixel_due.y, o_pixel_y);
                    mismatches++;
                end
                if (o_pixel_colour !== pixel_due.col) begin
                    $display("%0t: pixel_colour expected %0d actual %0d", $time,
                             pixel_due.col, o_pixel_colour);
                    mismatches++;
                end
                if (o_last_of_step !== pixel_due.last) begin
                    $display("%0t: last_of_step expected %0b actual %0b", $time,
                             pixel_due.last, o_last_of_step);
                    mismatches++;
                end
                if (o_circle_done !== pixel_due.done) begin
                    $display("%0t: circle_done expected %0b actual %0b", $time,
                             pixel_due.done, o_circle_done);
                    mismatches++;
                end
            end
        end
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(8, 80);
        end else begin
            rx_span--;
        end
        case (rx_mode)
            0: begin
                pop <= !rx_hold;
            end
            1: begin
                pop <= !rx_hold && ($urandom_range(0, 1) == 1);
            end
            default: begin
                pop <= !rx_hold && (rx_span % 3 == 0);
            end
        endcase
    end

    // hold off the receiver long enough to back up the input
    initial begin
        wait (random_phase);
        repeat (20) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        t_stim_row   row;
        int unsigned sel;
        int unsigned cap;
        int unsigned n;
        bit          drained_mid;
        drained_mid = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIR_ROWS; i++) offer(dir_rows[i]);
        wait_drained();
        random_phase = 1'b1;
        items_sent   = 0;
        while (items_sent < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                offer(rand_row(logic'($urandom_range(0, 1))));
            end else begin
                row = rand_row(KIND_START);
                if (sel < 60) row.r = COORD_BITS'($urandom_range(0, 15));
                else if (sel < 85) row.r = COORD_BITS'($urandom_range(16, 80));
                if (sel >= 85 || (sel >= 50 && sel < 60)) cap = $urandom_range(0, 12);
                else cap = 1000;
                offer(row);
                n = 0;
                while (circle_active && n < cap) begin
                    offer(rand_row(KIND_STEP));
                    n++;
                end
                if ($urandom_range(0, 3) == 0) offer(rand_row(KIND_STEP));
            end
            if (!drained_mid && items_sent >= RAND_ITEMS / 2) begin
                drained_mid = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
        repeat (24) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_queue.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_core.sv
dv/tb_midpoint_circle_rasterizer_core.sv
